### rtl/chd_pkg.sv
// ============================================================================
// chd_pkg
// Shared types for the chunk hash change detector: opcodes, result kinds,
// controller states and the command/status bundles between control and data.
// ============================================================================
package chd_pkg;

    localparam int ID_W   = 32;
    localparam int HASH_W = 256;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CHECK  = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_NEW     = 3'd0,
        KIND_CHANGED = 3'd1,
        KIND_REMOVED = 3'd2,
        KIND_END     = 3'd3,
        KIND_FULL    = 3'd4
    } kind_t;

    // source of the reported id
    typedef enum logic [1:0] {
        OUT_SEL_INPUT = 2'd0,
        OUT_SEL_SWEEP = 2'd1,
        OUT_SEL_ZERO  = 2'd2
    } out_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_LOOKUP = 3'd1,
        ST_ACT    = 3'd2,
        ST_CMP    = 3'd3,
        ST_SWEEP  = 3'd4,
        ST_SWEND  = 3'd5
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     lookup;
        logic     tbl_write;
        logic     mark_seen;
        logic     hash_rd;
        logic     sweep_step;
        logic     clear_all;
        logic     out_load;
        kind_t    out_kind;
        out_sel_t out_sel;
        logic     out_last;
    } chd_cmd_t;

    typedef struct packed {
        opcode_t opcode;
        logic    hit;
        logic    full;
        logic    hash_eq;
        logic    out_ready;
        logic    sweep_emit;
        logic    sweep_last;
    } chd_status_t;

endpackage

### rtl/chunk_hash_change_detector.sv
// ============================================================================
// chunk_hash_change_detector
// Compares a new list of chunk ids and hashes against a stored old list and
// streams out new, changed, removed, end-of-list and table-full reports.
// ============================================================================
// One transaction is handled at a time. A load is accepted, matched
// against the table and written, or reported as table-full. A check is
// accepted and matched across the table; a present id then has its hash
// memory row read and goes on to a 256-bit hash compare, while an absent
// id skips the compare. The id match over all TABLE_DEPTH entries is
// registered before the hash memory is addressed. An unused opcode is
// accepted and has no effect. A finish walks the table one entry per cycle
// while no removed report has to wait for the downstream side to take an
// earlier report, then loads an end-of-list report. Results sit in an
// output register, so a reported result may wait on m_tready while the
// block goes back to accepting input; the block stalls only when a second
// result is due before the first has been taken. Duplicate old ids share
// one entry. Hash contents of entries never loaded are never read. After
// reset the table is empty; no clearing pass is needed.
module chunk_hash_change_detector
    import chd_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] chunk id, [95:32] hash_word0, [159:96] hash_word1,
    // [223:160] hash_word2, [287:224] hash_word3
    input  logic [287:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] changed_id
    output logic [31:0]  m_tdata,
    // [2:0] change_kind
    output logic [2:0]   m_tuser,
    // last_of_run
    output logic         m_tlast
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    chd_cmd_t    cmd;
    chd_status_t status;
    kind_t       out_kind;

    chd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser),
        .in_ready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    chd_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_opcode (s_tuser),
        .in_id     (s_tdata[31:0]),
        .in_hash   (s_tdata[287:32]),
        .out_taken (m_tready),
        .out_valid (m_tvalid),
        .out_id    (m_tdata),
        .out_kind  (out_kind),
        .out_last  (m_tlast)
    );

    assign m_tuser = out_kind;

endmodule

### rtl/chd_ctrl.sv
// ============================================================================
// chd_ctrl
// Sequencer: accepts one transaction, steps it through lookup, action and
// hash compare, or walks the table on a finish.
// ============================================================================
module chd_ctrl
    import chd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  in_opcode,
    output logic        in_ready,
    input  chd_status_t status,
    output chd_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    opcode_t in_op;

    assign in_op = opcode_t'(in_opcode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_op)
                        OP_LOAD, OP_CHECK: state_next = ST_LOOKUP;
                        OP_FINISH:         state_next = ST_SWEEP;
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                if (status.opcode == OP_LOAD)
                begin
                    if (!status.full || status.hit || status.out_ready)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (status.hit)
                begin
                    state_next = ST_CMP;
                end
                else if (status.out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CMP:
            begin
                if (status.hash_eq || status.out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (status.sweep_last && (!status.sweep_emit || status.out_ready))
                begin
                    state_next = ST_SWEND;
                end
            end
            ST_SWEND:
            begin
                if (status.out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.out_kind = KIND_NEW;
        cmd.out_sel  = OUT_SEL_INPUT;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            ST_ACT:
            begin
                if (status.opcode == OP_LOAD)
                begin
                    if (status.hit || !status.full)
                    begin
                        cmd.tbl_write = 1'b1;
                    end
                    else
                    begin
                        cmd.out_load = status.out_ready;
                        cmd.out_kind = KIND_FULL;
                        cmd.out_last = 1'b1;
                    end
                end
                else if (status.hit)
                begin
                    cmd.mark_seen = 1'b1;
                    cmd.hash_rd   = 1'b1;
                end
                else
                begin
                    cmd.out_load = status.out_ready;
                    cmd.out_kind = KIND_NEW;
                    cmd.out_last = 1'b1;
                end
            end
            ST_CMP:
            begin
                cmd.out_load = !status.hash_eq && status.out_ready;
                cmd.out_kind = KIND_CHANGED;
                cmd.out_last = 1'b1;
            end
            ST_SWEEP:
            begin
                cmd.out_kind   = KIND_REMOVED;
                cmd.out_sel    = OUT_SEL_SWEEP;
                cmd.out_load   = status.sweep_emit && status.out_ready;
                cmd.sweep_step = !status.sweep_emit || status.out_ready;
            end
            ST_SWEND:
            begin
                cmd.out_kind  = KIND_END;
                cmd.out_sel   = OUT_SEL_ZERO;
                cmd.out_last  = 1'b1;
                cmd.out_load  = status.out_ready;
                cmd.clear_all = status.out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/chd_datapath.sv
// ============================================================================
// chd_datapath
// Entry table (id match array, valid and seen marks), hash memory, sweep
// index, input capture and the result register.
// ============================================================================
module chd_datapath
    import chd_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int IDX_W       = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  chd_cmd_t          cmd,
    output chd_status_t       status,
    input  logic [1:0]        in_opcode,
    input  logic [ID_W-1:0]   in_id,
    input  logic [HASH_W-1:0] in_hash,
    input  logic              out_taken,
    output logic              out_valid,
    output logic [ID_W-1:0]   out_id,
    output kind_t             out_kind,
    output logic              out_last
);

    // captured transaction
    opcode_t           op_reg;
    logic [ID_W-1:0]   id_in_reg;
    logic [HASH_W-1:0] hash_in_reg;

    // entry table
    logic [ID_W-1:0]        id_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] seen_reg;
    logic [HASH_W-1:0]      hash_mem [TABLE_DEPTH];
    logic [HASH_W-1:0]      hash_rd_reg;

    // lookup results
    logic             hit_reg;
    logic             full_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             hit_next;
    logic             free_found;
    logic [IDX_W-1:0] match_idx_next;
    logic [IDX_W-1:0] free_idx_next;
    logic [IDX_W-1:0] wr_idx;

    logic [IDX_W-1:0] sweep_idx_reg;
    logic             sweep_last;

    // result register
    logic            out_valid_reg;
    logic [ID_W-1:0] out_id_reg;
    kind_t           out_kind_reg;
    logic            out_last_reg;
    logic            out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= opcode_t'(in_opcode);
            id_in_reg   <= in_id;
            hash_in_reg <= in_hash;
        end
    end

    // lowest matching and lowest free entry; scan runs high to low so the
    // last assignment wins
    always_comb
    begin
        hit_next       = 1'b0;
        free_found     = 1'b0;
        match_idx_next = '0;
        free_idx_next  = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (id_reg[i] == id_in_reg))
            begin
                hit_next       = 1'b1;
                match_idx_next = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_found    = 1'b1;
                free_idx_next = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            full_reg <= 1'b0;
        end
        else if (cmd.lookup)
        begin
            hit_reg  <= hit_next;
            full_reg <= !free_found;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            match_idx_reg <= match_idx_next;
            free_idx_reg  <= free_idx_next;
        end
    end

    assign wr_idx = hit_reg ? match_idx_reg : free_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            seen_reg  <= '0;
        end
        else if (cmd.clear_all)
        begin
            valid_reg <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            if (cmd.tbl_write && !hit_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                seen_reg[free_idx_reg]  <= 1'b0;
            end
            if (cmd.mark_seen)
            begin
                seen_reg[match_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write && !hit_reg)
        begin
            id_reg[free_idx_reg] <= id_in_reg;
        end
    end

    // hash memory: one row per entry, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write)
        begin
            hash_mem[wr_idx] <= hash_in_reg;
        end
        if (cmd.hash_rd)
        begin
            hash_rd_reg <= hash_mem[match_idx_reg];
        end
    end

    // sweep index
    assign sweep_last = (sweep_idx_reg == IDX_W'(TABLE_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_idx_reg <= '0;
        end
        else if (cmd.sweep_step)
        begin
            sweep_idx_reg <= sweep_last ? '0 : sweep_idx_reg + 1'b1;
        end
    end

    // result register
    assign out_ready = !out_valid_reg || out_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_taken)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                OUT_SEL_INPUT: out_id_reg <= id_in_reg;
                OUT_SEL_SWEEP: out_id_reg <= id_reg[sweep_idx_reg];
                default:       out_id_reg <= '0;
            endcase
            out_kind_reg <= cmd.out_kind;
            out_last_reg <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_id    = out_id_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        status.opcode     = op_reg;
        status.hit        = hit_reg;
        status.full       = full_reg;
        status.hash_eq    = (hash_rd_reg == hash_in_reg);
        status.out_ready  = out_ready;
        status.sweep_emit = valid_reg[sweep_idx_reg] && !seen_reg[sweep_idx_reg];
        status.sweep_last = sweep_last;
    end

endmodule

### tb/sv/tb.sv
// ============================================================================
// tb: chunk hash change detector testbench
// Drives load, check and finish transactions into the detector and checks
// every report against a behavioural copy of the id/hash table kept here.
// Covers directed corner cases, a full table and random old/new list rounds
// with random input gaps and output back-pressure.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import chd_pkg::*;

    localparam int DEPTH        = 32;
    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 380;
    // a finish walks the whole table, so allow for it plus stalls
    localparam int DRAIN_CYCLES = 3 * DEPTH;

    // one expected report
    typedef struct packed {
        logic [31:0] id;
        kind_t       kind;
        logic        last;
    } report_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // [31:0] chunk id, [287:32] hash words 0..3
    logic [287:0] s_tdata  = '0;
    // [1:0] opcode
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [31:0] changed_id
    logic [31:0]  m_tdata;
    // [2:0] change_kind
    logic [2:0]   m_tuser;
    logic         m_tlast;

    // shadow of the detector table
    logic         tbl_valid [DEPTH];
    logic         tbl_seen  [DEPTH];
    logic [31:0]  tbl_id    [DEPTH];
    logic [255:0] tbl_hash  [DEPTH];

    report_t      pending_reports[$];

    // old list of the current random round, as the stimulus side sees it
    logic [31:0]  round_ids[$];
    logic [255:0] round_hashes[$];

    int error_count = 0;
    int sent_items  = 0;

    // sender bursts and receiver stalls
    int burst_left = 0;
    int burst_max  = 1;
    int gap_max    = 0;
    int stall_left = 0;
    int stall_pct  = 0;
    int stall_max  = 1;

    chunk_hash_change_detector #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic logic [255:0] rand_hash();
        logic [255:0] h;
        for (int w = 0; w < 8; w++)
        begin
            h[32*w +: 32] = $urandom;
        end
        return h;
    endfunction

    // small pool now and then, so that ids repeat within a round
    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom_range(0, 15);
        end
        return $urandom;
    endfunction

    function automatic void add_report(input logic [31:0] id, input kind_t kind,
                                       input logic last);
        report_t r;
        r.id   = id;
        r.kind = kind;
        r.last = last;
        pending_reports.insert(pending_reports.size(), r);
    endfunction

    // Applies one accepted transaction to the shadow table and queues the
    // reports it should produce, in order.
    function automatic void predict_reports(input opcode_t op, input logic [31:0] id,
                                            input logic [255:0] hash);
        int slot;
        int free_slot;
        slot      = -1;
        free_slot = -1;
        // walk downwards so that the lowest index wins
        for (int e = DEPTH - 1; e >= 0; e--)
        begin
            if (!tbl_valid[e])
            begin
                free_slot = e;
            end
            else if (tbl_id[e] == id)
            begin
                slot = e;
            end
        end
        unique case (op)
            OP_LOAD:
            begin
                if (slot < 0 && free_slot < 0)
                begin
                    add_report(id, KIND_FULL, 1'b1);
                end
                else
                begin
                    if (slot < 0)
                    begin
                        slot            = free_slot;
                        tbl_valid[slot] = 1'b1;
                        tbl_seen[slot]  = 1'b0;
                        tbl_id[slot]    = id;
                    end
                    // a repeated id only refreshes the hash
                    tbl_hash[slot] = hash;
                end
            end
            OP_CHECK:
            begin
                if (slot < 0)
                begin
                    add_report(id, KIND_NEW, 1'b1);
                end
                else
                begin
                    tbl_seen[slot] = 1'b1;
                    if (tbl_hash[slot] != hash)
                    begin
                        add_report(id, KIND_CHANGED, 1'b1);
                    end
                end
            end
            OP_FINISH:
            begin
                for (int e = 0; e < DEPTH; e++)
                begin
                    if (tbl_valid[e] && !tbl_seen[e])
                    begin
                        add_report(tbl_id[e], KIND_REMOVED, 1'b0);
                    end
                    tbl_valid[e] = 1'b0;
                    tbl_seen[e]  = 1'b0;
                end
                add_report(32'd0, KIND_END, 1'b1);
            end
            default:
            begin
                // unused opcode: no effect
            end
        endcase
    endfunction

    // Sends one transaction. Called just after a rising edge; returns just
    // after the edge at which it was accepted, with s_tvalid still high.
    task automatic push_item(input opcode_t op, input logic [31:0] id,
                             input logic [255:0] hash);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {hash, id};
        do @(posedge clk); while (!s_tready);
        predict_reports(op, id, hash);
        if (op != OP_NONE)
        begin
            sent_items++;
        end
    endtask

    // Loads an old entry and keeps the round's own list in step with it.
    task automatic load_old(input logic [31:0] id, input logic [255:0] hash);
        int idx;
        idx = -1;
        for (int i = 0; i < round_ids.size(); i++)
        begin
            if (round_ids[i] == id)
            begin
                idx = i;
            end
        end
        push_item(OP_LOAD, id, hash);
        if (idx >= 0)
        begin
            round_hashes[idx] = hash;
        end
        else if (round_ids.size() < DEPTH)
        begin
            round_ids.insert(round_ids.size(), id);
            round_hashes.insert(round_hashes.size(), hash);
        end
    endtask

    task automatic set_idling(input int mode);
        unique case (mode)
            0:
            begin
                gap_max = 0; burst_max = 1;  stall_pct = 0;  stall_max = 1;
            end
            1:
            begin
                gap_max = 2; burst_max = 8;  stall_pct = 10; stall_max = 2;
            end
            2:
            begin
                gap_max = 6; burst_max = 3;  stall_pct = 5;  stall_max = 2;
            end
            default:
            begin
                gap_max = 1; burst_max = 16; stall_pct = 40; stall_max = 8;
            end
        endcase
    endtask

    // Result side: check each accepted report, then pick the next ready.
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                note_error($sformatf("unexpected report: id %h kind %0d last %0d",
                                     m_tdata, m_tuser, m_tlast));
            end
            else
            begin
                want = pending_reports.pop_front();
                if (m_tdata !== want.id || m_tuser !== want.kind || m_tlast !== want.last)
                begin
                    note_error($sformatf(
                        "report mismatch: expected id %h kind %0d last %0d, got id %h kind %0d last %0d",
                        want.id, want.kind, want.last, m_tdata, m_tuser, m_tlast));
                end
            end
        end
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, stall_max);
            end
        end
    end

    // Corner cases: empty finish, id and hash extremes, duplicate loads,
    // matching and changed checks, repeats, unused opcode, table emptied.
    task automatic test_directed();
        logic [255:0] hash_a;
        hash_a = 256'h0123456789abcdef_fedcba9876543210_a5a5a5a55a5a5a5a_0f0f0f0ff0f0f0f0;
        set_idling(0);
        push_item(OP_FINISH, 32'd0, '0);                   // empty table: end only
        push_item(OP_LOAD,   32'h0000_0000, '0);
        push_item(OP_LOAD,   32'hffff_ffff, '1);
        push_item(OP_LOAD,   32'h0000_0000, hash_a);       // overwrite in place
        push_item(OP_LOAD,   32'h1234_5678, rand_hash());  // never checked
        push_item(OP_CHECK,  32'h0000_0000, hash_a);       // match, silent
        push_item(OP_CHECK,  32'hffff_ffff, {1'b0, {255{1'b1}}});
        push_item(OP_CHECK,  32'hffff_ffff, {1'b0, {255{1'b1}}}); // reported again
        push_item(OP_CHECK,  32'h0000_0000, '0);           // stale hash
        push_item(OP_CHECK,  32'hdead_beef, '1);           // absent
        push_item(OP_CHECK,  32'hdead_beef, '1);
        push_item(OP_NONE,   32'h1234_5678, '1);           // ignored
        push_item(OP_FINISH, 32'hffff_ffff, '1);
        push_item(OP_CHECK,  32'h0000_0000, hash_a);       // table was emptied
        push_item(OP_FINISH, 32'd0, '0);
    endtask

    // Fill every slot, overflow it, refresh a present id while full, sweep.
    task automatic test_table_full();
        logic [31:0]  ids    [DEPTH];
        logic [255:0] hashes [DEPTH];
        set_idling(3);
        for (int i = 0; i < DEPTH; i++)
        begin
            ids[i]    = {i[4:0], 27'($urandom)};
            hashes[i] = rand_hash();
            push_item(OP_LOAD, ids[i], hashes[i]);
        end
        push_item(OP_LOAD, ids[0] ^ 32'd1, rand_hash());   // no free slot
        hashes[7] = rand_hash();
        push_item(OP_LOAD, ids[7], hashes[7]);             // present id still fits
        push_item(OP_CHECK, ids[7], hashes[7]);
        for (int i = 0; i < DEPTH; i += 2)
        begin
            push_item(OP_CHECK, ids[i], hashes[i]);
        end
        push_item(OP_CHECK, ids[3], hashes[3] ^ (256'b1 << $urandom_range(0, 255)));
        push_item(OP_FINISH, $urandom, rand_hash());
    endtask

    // Rounds of: load an old list, check a new list against it, finish.
    // Mostly well formed, with stray loads, unused opcodes and rounds that
    // skip the finish so that the table carries over.
    task automatic test_random_lists();
        int start;
        int n_load;
        int n_check;
        int idx;
        int roll;
        start = sent_items;
        while (sent_items - start < RANDOM_ITEMS)
        begin
            set_idling($urandom_range(0, 3));
            n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                 : $urandom_range(0, 12);
            for (int i = 0; i < n_load; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    push_item(OP_NONE, $urandom, rand_hash());
                end
                load_old(pick_id(), rand_hash());
            end
            n_check = $urandom_range(0, round_ids.size() + 4);
            for (int i = 0; i < n_check; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                begin
                    load_old(pick_id(), rand_hash());
                end
                else if (roll < 8)
                begin
                    push_item(OP_NONE, $urandom, rand_hash());
                end
                else if (roll < 70 && round_ids.size() != 0)
                begin
                    idx = $urandom_range(0, round_ids.size() - 1);
                    push_item(OP_CHECK, round_ids[idx], round_hashes[idx]);
                end
                else if (roll < 85 && round_ids.size() != 0)
                begin
                    idx = $urandom_range(0, round_ids.size() - 1);
                    push_item(OP_CHECK, round_ids[idx],
                              round_hashes[idx] ^ (256'b1 << $urandom_range(0, 255)));
                end
                else
                begin
                    push_item(OP_CHECK, pick_id(), rand_hash());
                end
            end
            if ($urandom_range(0, 99) >= 15)
            begin
                push_item(OP_FINISH, $urandom, rand_hash());
                round_ids.delete();
                round_hashes.delete();
            end
        end
    endtask

    initial
    begin
        for (int e = 0; e < DEPTH; e++)
        begin
            tbl_valid[e] = 1'b0;
            tbl_seen[e]  = 1'b0;
            tbl_id[e]    = '0;
            tbl_hash[e]  = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        test_random_lists();

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("chunk_hash_change_detector test passed");
        end
        else
        begin
            $display("chunk_hash_change_detector test failed");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #10000000;
        $display("chunk_hash_change_detector test failed");
        $finish;
    end

endmodule
